/* hdl/epdm_pkg.sv */
// Shared types and constants for the echo pulse distance median block.
package epdm_pkg;

   localparam int TS_BITS        = 32;
   localparam int TIMEOUT_BITS   = 16;
   localparam int CM_BITS        = 10;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 16'd30000;
   localparam logic [CM_BITS-1:0]      FAR_RESET     = 10'd999;
   localparam logic [CM_BITS-1:0]      DIST_MAX      = 10'd1023;

   // floor(d / 58) = floor((d >> 1) * RECIP >> RECIP_SHIFT) for d below 2^16
   localparam int                  HALF_BITS   = TIMEOUT_BITS - 1;
   localparam int                  RECIP_BITS  = 20;
   localparam int                  RECIP_SHIFT = 24;
   localparam logic [RECIP_BITS-1:0] CM_RECIP  = 20'd578525;
   localparam int                  PROD_BITS   = HALF_BITS + RECIP_BITS;
   localparam int                  QUOT_BITS   = PROD_BITS - RECIP_SHIFT;

   typedef enum logic {
      CSR_TIMEOUT = 1'b0,
      CSR_FAR     = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [TIMEOUT_BITS-1:0] timeout_us;
      logic [CM_BITS-1:0]      far_value_cm;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [CM_BITS-1:0] cm;
   } dist_xfer_type;

endpackage

/* hdl/echo_pulse_distance_median.sv */
// Echo pulse distance with three-sample median, top level.
// Takes one edge event per clock unless req_stall is high: a rising edge records its
// timestamp, an armed falling edge turns the pulse width into centimeters (width / 58,
// or the far value past the timeout) and yields one result carrying that distance and
// the median of the last three. The event lands in the input register at its transfer,
// its distance then loads the distance register (subtract, compare and one reciprocal
// multiply), and then the ring and result register, which drives rsp_valid. Throughput
// is one event per clock while rsp_stall stays low; events that yield no result leave
// the pipeline without waiting on the result side. The ring starts at 999 cm on reset;
// writing far_value_cm does not alter it.
module echo_pulse_distance_median (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_edge_level,
   input  logic [epdm_pkg::TS_BITS-1:0]         req_time_us,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [epdm_pkg::CM_BITS-1:0]         rsp_median_cm,
   output logic [epdm_pkg::CM_BITS-1:0]         rsp_newest_cm,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [epdm_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [epdm_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [epdm_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import epdm_pkg::*;

   cfg_type       cfg;
   dist_xfer_type dist_xfer;
   logic          med_ready;

   epdm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   epdm_dist u_dist (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_edge_level (req_edge_level),
      .req_time_us    (req_time_us),
      .cfg            (cfg),
      .med_ready      (med_ready),
      .dist_out       (dist_xfer)
   );

   epdm_median u_median (
      .clock         (clock),
      .reset         (reset),
      .dist_in       (dist_xfer),
      .med_ready     (med_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_median_cm (rsp_median_cm),
      .rsp_newest_cm (rsp_newest_cm)
   );

endmodule

/* hdl/epdm_csr.sv */
// Configuration registers behind the APB-style port.
module epdm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [epdm_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [epdm_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [epdm_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output epdm_pkg::cfg_type                    cfg
);
   import epdm_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type sel_reg;
   logic        wr_xfer;

   assign pready  = 1'b1;
   assign sel_reg = csr_reg_type'(paddr[2]);
   assign wr_xfer = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_xfer) begin
         case (sel_reg)
            CSR_TIMEOUT: cfg_in.timeout_us   = pwdata[TIMEOUT_BITS-1:0];
            CSR_FAR:     cfg_in.far_value_cm = pwdata[CM_BITS-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_us   <= TIMEOUT_RESET;
         cfg_ff.far_value_cm <= FAR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (sel_reg)
         CSR_TIMEOUT: prdata = {{(CSR_DATA_BITS-TIMEOUT_BITS){1'b0}}, cfg_ff.timeout_us};
         CSR_FAR:     prdata = {{(CSR_DATA_BITS-CM_BITS){1'b0}}, cfg_ff.far_value_cm};
         default:     prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/epdm_dist.sv */
// Input register, pulse timing and duration-to-centimeter conversion stage.
module epdm_dist (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_edge_level,
   input  logic [epdm_pkg::TS_BITS-1:0]  req_time_us,
   input  epdm_pkg::cfg_type             cfg,
   input  logic                          med_ready,
   output epdm_pkg::dist_xfer_type       dist_out
);
   import epdm_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic               in_level_ff;
   logic [TS_BITS-1:0] in_time_ff;
   logic               armed_ff, armed_in;
   logic [TS_BITS-1:0] start_ff, start_in;
   logic               dist_valid_ff, dist_valid_in;
   logic [CM_BITS-1:0] dist_cm_ff, dist_cm_in;

   logic                 req_xfer;
   logic                 makes_dist;
   logic                 dist_ready;
   logic                 in_adv;
   logic [TS_BITS-1:0]   dur;
   logic                 over;
   logic [HALF_BITS-1:0] half;
   logic [PROD_BITS-1:0] prod;
   logic [QUOT_BITS-1:0] quot;
   logic [CM_BITS-1:0]   cm_calc;

   assign makes_dist = !in_level_ff && armed_ff;
   assign dist_ready = !dist_valid_ff || med_ready;
   assign in_adv     = in_valid_ff && (!makes_dist || dist_ready);
   assign req_stall  = in_valid_ff && !in_adv;
   assign req_xfer   = req_valid && !req_stall;

   assign dur  = in_time_ff - start_ff;
   assign over = dur > {{(TS_BITS-TIMEOUT_BITS){1'b0}}, cfg.timeout_us};
   assign half = dur[TIMEOUT_BITS-1:1];
   assign prod = {{RECIP_BITS{1'b0}}, half} * {{HALF_BITS{1'b0}}, CM_RECIP};
   assign quot = prod[PROD_BITS-1:RECIP_SHIFT];

   always_comb begin
      if (over) begin
         cm_calc = cfg.far_value_cm;
      end else if (quot > {{(QUOT_BITS-CM_BITS){1'b0}}, DIST_MAX}) begin
         cm_calc = DIST_MAX;
      end else begin
         cm_calc = quot[CM_BITS-1:0];
      end
   end

   always_comb begin
      in_valid_in   = in_valid_ff;
      armed_in      = armed_ff;
      start_in      = start_ff;
      dist_valid_in = dist_valid_ff;
      dist_cm_in    = dist_cm_ff;
      if (dist_valid_ff && med_ready) begin
         dist_valid_in = 1'b0;
      end
      if (in_adv) begin
         in_valid_in = 1'b0;
         if (in_level_ff) begin
            armed_in = 1'b1;
            start_in = in_time_ff;
         end else if (armed_ff) begin
            armed_in      = 1'b0;
            dist_valid_in = 1'b1;
            dist_cm_in    = cm_calc;
         end
      end
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         armed_ff      <= 1'b0;
         start_ff      <= '0;
         dist_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         armed_ff      <= armed_in;
         start_ff      <= start_in;
         dist_valid_ff <= dist_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_cm_ff <= dist_cm_in;
      if (req_xfer) begin
         in_level_ff <= req_edge_level;
         in_time_ff  <= req_time_us;
      end
   end

   assign dist_out.valid = dist_valid_ff;
   assign dist_out.cm    = dist_cm_ff;

   a_fall_disarms: assert property (@(posedge clock) disable iff (reset)
      in_adv && !in_level_ff |=> !armed_ff)
      else $error("falling edge left the pulse armed");

   a_rise_arms: assert property (@(posedge clock) disable iff (reset)
      in_adv && in_level_ff |=> armed_ff && start_ff == $past(in_time_ff))
      else $error("rising edge did not capture start time");

   a_dist_holds: assert property (@(posedge clock) disable iff (reset)
      dist_valid_ff && !med_ready |=> dist_valid_ff && $stable(dist_cm_ff))
      else $error("pending distance changed while blocked");

endmodule

/* hdl/epdm_median.sv */
// Three-entry distance ring, median select and result register.
module epdm_median (
   input  logic                           clock,
   input  logic                           reset,
   input  epdm_pkg::dist_xfer_type        dist_in,
   output logic                           med_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [epdm_pkg::CM_BITS-1:0]   rsp_median_cm,
   output logic [epdm_pkg::CM_BITS-1:0]   rsp_newest_cm
);
   import epdm_pkg::*;

   logic [CM_BITS-1:0] ring_ff [3];
   logic [CM_BITS-1:0] ring_in [3];
   logic [1:0]         slot_ff, slot_in;
   logic               out_valid_ff, out_valid_in;
   logic [CM_BITS-1:0] median_ff, median_in;
   logic [CM_BITS-1:0] newest_ff, newest_in;
   logic               load;

   function automatic logic [CM_BITS-1:0] med3(input logic [CM_BITS-1:0] a,
                                                input logic [CM_BITS-1:0] b,
                                                input logic [CM_BITS-1:0] c);
      logic [CM_BITS-1:0] hi;
      logic [CM_BITS-1:0] lo;
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      if (c > hi) begin
         return hi;
      end else if (c < lo) begin
         return lo;
      end
      return c;
   endfunction

   assign med_ready = !out_valid_ff || !rsp_stall;
   assign load      = dist_in.valid && med_ready;

   always_comb begin
      ring_in      = ring_ff;
      slot_in      = slot_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      median_in    = median_ff;
      newest_in    = newest_ff;
      if (load) begin
         case (slot_ff)
            2'd1: begin
               ring_in[1] = dist_in.cm;
               slot_in    = 2'd2;
            end
            2'd2: begin
               ring_in[2] = dist_in.cm;
               slot_in    = 2'd0;
            end
            default: begin
               ring_in[0] = dist_in.cm;
               slot_in    = 2'd1;
            end
         endcase
         out_valid_in = 1'b1;
         median_in    = med3(ring_in[0], ring_in[1], ring_in[2]);
         newest_in    = dist_in.cm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff[0]   <= FAR_RESET;
         ring_ff[1]   <= FAR_RESET;
         ring_ff[2]   <= FAR_RESET;
         slot_ff      <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         ring_ff      <= ring_in;
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      median_ff <= median_in;
      newest_ff <= newest_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_median_cm = median_ff;
   assign rsp_newest_cm = newest_ff;

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff != 2'd3)
      else $error("ring slot out of range");

   a_slot_step: assert property (@(posedge clock) disable iff (reset)
      load |=> slot_ff == (($past(slot_ff) == 2'd2) ? 2'd0 : $past(slot_ff) + 2'd1))
      else $error("ring slot did not advance");

   a_median_member: assert property (@(posedge clock) disable iff (reset)
      load |=> median_ff == ring_ff[0] || median_ff == ring_ff[1]
               || median_ff == ring_ff[2])
      else $error("median is not a ring entry");

endmodule

/* dv/echo_pulse_distance_median_tb.sv */
// Self-checking testbench for the echo pulse distance median block.
module echo_pulse_distance_median_tb;
   import epdm_pkg::*;

   localparam int CM_DIVISOR   = 58;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_EDGES  = 500;
   localparam int PRINT_CAP    = 100;

   typedef enum logic {
      ROW_EDGE,
      ROW_WRITE
   } row_kind_type;

   typedef struct packed {
      logic [CM_BITS-1:0] median;
      logic [CM_BITS-1:0] newest;
   } distance_pair_type;

   typedef struct packed {
      row_kind_type        kind;
      logic                level;
      logic [TS_BITS-1:0]  value;
      csr_reg_type         csr_sel;
      logic                typed;
      distance_pair_type   want;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_edge_level = 1'b0;
   logic [TS_BITS-1:0]       req_time_us = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [CM_BITS-1:0]       rsp_median_cm;
   logic [CM_BITS-1:0]       rsp_newest_cm;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   echo_pulse_distance_median dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_edge_level (req_edge_level),
      .req_time_us    (req_time_us),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_median_cm  (rsp_median_cm),
      .rsp_newest_cm  (rsp_newest_cm),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   logic [TS_BITS-1:0]      echo_start;
   logic                    echo_armed;
   logic [CM_BITS-1:0]      echo_ring [3];
   int                      echo_slot;
   logic [TIMEOUT_BITS-1:0] timeout_shadow;
   logic [CM_BITS-1:0]      far_shadow;

   distance_pair_type pending_distances[$];
   stim_row_type      directed_rows[$];
   distance_pair_type arrived_want;

   int error_count     = 0;
   int edges_sent      = 0;
   int used_edges      = 0;
   int results_checked = 0;
   int writes_done     = 0;
   int cycle_count     = 0;
   int tx_idle_pct     = 0;
   int rx_stall_pct    = 0;
   int hold_len        = 0;
   int hold_seq        = 0;
   int hold_seen       = 0;
   int hold_left       = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_CAP) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
      error_count++;
   endtask

   function automatic logic [CM_BITS-1:0] median_of3(input logic [CM_BITS-1:0] a,
                                                     input logic [CM_BITS-1:0] b,
                                                     input logic [CM_BITS-1:0] c);
      if ((a >= b && a <= c) || (a <= b && a >= c)) begin
         return a;
      end
      if ((b >= a && b <= c) || (b <= a && b >= c)) begin
         return b;
      end
      return c;
   endfunction

   function automatic logic measure_echo_edge(input logic lvl, input logic [TS_BITS-1:0] t,
                                              output distance_pair_type res);
      logic [TS_BITS-1:0] width;
      logic [TS_BITS-1:0] quot;
      logic [CM_BITS-1:0] cm;
      res = '0;
      if (lvl) begin
         echo_start = t;
         echo_armed = 1'b1;
         return 1'b0;
      end
      if (!echo_armed) begin
         return 1'b0;
      end
      echo_armed = 1'b0;
      width = t - echo_start;
      if (width > {{(TS_BITS-TIMEOUT_BITS){1'b0}}, timeout_shadow}) begin
         cm = far_shadow;
      end else begin
         quot = width / CM_DIVISOR;
         cm = (quot > DIST_MAX) ? DIST_MAX : quot[CM_BITS-1:0];
      end
      echo_ring[echo_slot] = cm;
      echo_slot = (echo_slot + 1) % 3;
      res.median = median_of3(echo_ring[0], echo_ring[1], echo_ring[2]);
      res.newest = cm;
      return 1'b1;
   endfunction

   function automatic void add_edge(input logic lvl, input logic [TS_BITS-1:0] t);
      stim_row_type row;
      row = '0;
      row.kind = ROW_EDGE;
      row.level = lvl;
      row.value = t;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(input logic lvl, input logic [TS_BITS-1:0] t,
                                       input logic [CM_BITS-1:0] med,
                                       input logic [CM_BITS-1:0] newest);
      stim_row_type row;
      row = '0;
      row.kind = ROW_EDGE;
      row.level = lvl;
      row.value = t;
      row.typed = 1'b1;
      row.want.median = med;
      row.want.newest = newest;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(input csr_reg_type sel, input logic [TS_BITS-1:0] v);
      stim_row_type row;
      row = '0;
      row.kind = ROW_WRITE;
      row.csr_sel = sel;
      row.value = v;
      directed_rows.push_back(row);
   endfunction

   task automatic send_edge(input logic lvl, input logic [TS_BITS-1:0] t, input logic typed,
                            input distance_pair_type want);
      distance_pair_type predicted;
      logic made;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_edge_level <= lvl;
      req_time_us <= t;
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         @(posedge clock);
      end
      made = measure_echo_edge(lvl, t, predicted);
      edges_sent++;
      if (lvl || made) begin
         used_edges++;
      end
      if (made) begin
         pending_distances.push_back(typed ? want : predicted);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_distances.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic settle_block();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_register(input csr_reg_type sel, input logic [CSR_DATA_BITS-1:0] v);
      logic [CSR_DATA_BITS-1:0] mask;
      mask = (sel == CSR_TIMEOUT) ? 32'h0000_FFFF : 32'h0000_03FF;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (sel == CSR_TIMEOUT) begin
         timeout_shadow = v[TIMEOUT_BITS-1:0];
      end else begin
         far_shadow = v[CM_BITS-1:0];
      end
      writes_done++;
      // read back
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if ((prdata & mask) !== (v & mask)) begin
         report_mismatch($sformatf("%s readback %0h, wrote %0h", sel.name(), prdata & mask,
                                   v & mask));
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_random_pulse();
      logic [TS_BITS-1:0] start;
      logic [TS_BITS-1:0] width;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_edge(1'b0, $urandom(), 1'b0, '0);
      end else if (pick < 15) begin
         send_edge(1'b1, $urandom(), 1'b0, '0);
      end
      start = $urandom();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: width = $urandom_range(timeout_shadow);
         6, 7: width = timeout_shadow + $urandom_range(4) - 2;
         8: width = $urandom();
         default: width = $urandom_range(65535);
      endcase
      send_edge(1'b1, start, 1'b0, '0);
      send_edge(1'b0, start + width, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = hold_len;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_distances.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer median %0d newest %0d",
                                      rsp_median_cm, rsp_newest_cm));
         end else begin
            arrived_want = pending_distances.pop_front();
            results_checked++;
            if (rsp_median_cm !== arrived_want.median) begin
               report_mismatch($sformatf("median_cm %0d, expected %0d", rsp_median_cm,
                                         arrived_want.median));
            end
            if (rsp_newest_cm !== arrived_want.newest) begin
               report_mismatch($sformatf("newest_cm %0d, expected %0d", rsp_newest_cm,
                                         arrived_want.newest));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("echo_pulse_distance_median: mismatch");
         $finish;
      end
   end

   initial begin
      int phase_goal;
      logic paused_once;
      echo_start = '0;
      echo_armed = 1'b0;
      echo_ring[0] = FAR_RESET;
      echo_ring[1] = FAR_RESET;
      echo_ring[2] = FAR_RESET;
      echo_slot = 0;
      timeout_shadow = TIMEOUT_RESET;
      far_shadow = FAR_RESET;
      paused_once = 1'b0;

      add_edge(1'b0, 32'h0000_0000);
      add_edge(1'b1, 32'd1000);
      add_checked(1'b0, 32'd1000, 10'd999, 10'd0);
      add_edge(1'b1, 32'hFFFF_FFF0);
      add_checked(1'b0, 32'h0000_0010, 10'd0, 10'd0);
      add_edge(1'b1, 32'd500);
      add_edge(1'b1, 32'd2000);
      add_edge(1'b0, 32'd2058);
      add_edge(1'b1, 32'd0);
      add_edge(1'b0, 32'd30000);
      add_edge(1'b1, 32'd0);
      add_edge(1'b0, 32'd30001);
      add_edge(1'b1, 32'h0000_0000);
      add_checked(1'b0, 32'hFFFF_FFFF, 10'd999, 10'd999);
      add_write(CSR_TIMEOUT, 32'h0000_FFFF);
      add_write(CSR_FAR, 32'h0000_03FF);
      add_edge(1'b1, 32'd100);
      add_checked(1'b0, 32'd65635, 10'd999, 10'd1023);
      add_edge(1'b1, 32'd0);
      add_edge(1'b0, 32'd59391);
      add_edge(1'b1, 32'd0);
      add_edge(1'b0, 32'd59392);
      add_edge(1'b1, 32'd0);
      add_edge(1'b0, 32'd65536);
      add_write(CSR_TIMEOUT, 32'hFFFF_0000);
      add_write(CSR_FAR, 32'hFFFF_FC00);
      add_edge(1'b1, 32'd7);
      add_edge(1'b0, 32'd7);
      add_edge(1'b1, 32'd7);
      add_edge(1'b0, 32'd8);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            settle_block();
            program_register(directed_rows[i].csr_sel, directed_rows[i].value);
         end else begin
            send_edge(directed_rows[i].level, directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].want);
         end
      end

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               tx_idle_pct = 0;
               rx_stall_pct = 0;
            end
            1: begin
               tx_idle_pct = 64;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct = 0;
               rx_stall_pct = 64;
            end
            default: begin
               tx_idle_pct = 17;
               rx_stall_pct = 17;
            end
         endcase
         settle_block();
         case (p)
            0: begin
               program_register(CSR_TIMEOUT, {16'($urandom()), 16'd30000});
               program_register(CSR_FAR, {22'($urandom()), 10'd999});
            end
            1: begin
               program_register(CSR_TIMEOUT, {16'($urandom()), 16'hFFFF});
               program_register(CSR_FAR, {22'($urandom()), 10'd0});
            end
            2: begin
               program_register(CSR_TIMEOUT, {16'($urandom()), 16'($urandom_range(65535, 1))});
               program_register(CSR_FAR, {22'($urandom()), 10'($urandom_range(1023))});
            end
            default: begin
               program_register(CSR_TIMEOUT, {16'($urandom()), 16'($urandom_range(2000))});
               program_register(CSR_FAR, {22'($urandom()), 10'd1023});
            end
         endcase
         // back-pressure the result side while the sender keeps offering
         if (p == 0) begin
            hold_len = 400;
            hold_seq++;
         end
         phase_goal = used_edges + PHASE_EDGES;
         while (used_edges < phase_goal) begin
            send_random_pulse();
            if (p == 2 && !paused_once && used_edges >= phase_goal - PHASE_EDGES / 2) begin
               paused_once = 1'b1;
               wait_for_results();
            end
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d edge transfers (%0d rising or completing), %0d results checked.",
               edges_sent, used_edges, results_checked);
      $display("Register writes: %0d, idle and stall phases: 4, mismatches: %0d.",
               writes_done, error_count);
      if (error_count == 0) begin
         $display("echo_pulse_distance_median: match");
      end else begin
         $display("echo_pulse_distance_median: mismatch");
      end
      $finish;
   end

endmodule
